// ===== design/pairwise_distance_3d_defines.svh =====
// Assertion macros for the pairwise distance block.
// Used by the port checker; depends on nothing else.
`ifndef PAIRWISE_DISTANCE_3D_DEFINES_SVH
`define PAIRWISE_DISTANCE_3D_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pairwise distance check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pairwise distance check failed");

`endif

// ===== design/pwd_pkg.sv =====
// Shared widths and types for the pairwise distance block.
// No dependencies; imported by every module of the block.
package pwd_pkg;

    localparam int COORD_W    = 24;                 // one coordinate
    localparam int N_COORD    = 6;                  // coordinates per transfer
    localparam int IN_DATA_W  = COORD_W * N_COORD;  // 144 bits, whole bytes
    localparam int MAG_W      = COORD_W;            // |difference| fits 24 bits
    localparam int SQ_W       = 2 * MAG_W;          // one squared difference
    localparam int SUM_W      = SQ_W + 2;           // sum of three squares
    localparam int DIST_W     = SUM_W / 2;          // root bits, one per stage
    localparam int OUT_DATA_W = 32;                 // distance padded to bytes
    localparam int REM_W      = DIST_W + 1;         // partial remainder <= 2*root

    // Pipeline control handed to the root unit.
    typedef struct packed {
        logic ce;     // whole pipeline advances
        logic valid;  // an item enters the root unit
    } t_sqrt_ctl;

endpackage

// ===== design/pwd_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on pwd_pkg for widths and the control struct.
module pwd_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pwd_pkg::t_sqrt_ctl         i_ctl,
    input  logic [pwd_pkg::SUM_W-1:0]  i_radicand,
    output logic                       o_valid,
    output logic [pwd_pkg::DIST_W-1:0] o_root
);
    import pwd_pkg::*;

    logic [DIST_W-1:0] r_vld;
    logic [DIST_W-1:0] r_root [DIST_W];
    logic [REM_W-1:0]  r_rem  [DIST_W-1];
    logic [SUM_W-1:0]  r_rad  [DIST_W-1];

    for (genvar k = 0; k < DIST_W; k++) begin : g_stage
        logic [REM_W-1:0]  w_rem_in;
        logic [DIST_W-1:0] w_root_in;
        logic [SUM_W-1:0]  w_rad_in;
        logic              w_vld_in;
        logic [REM_W+1:0]  w_cur;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_radicand;
            assign w_vld_in  = i_ctl.valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        // Bring down the next pair of radicand bits and try root*4+1.
        assign w_cur   = {w_rem_in, w_rad_in[SUM_W-1 -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};
        assign w_diff  = w_cur - w_trial;
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.ce) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.ce) begin
                r_root[k] <= {w_root_in[DIST_W-2:0], w_ge};
            end
        end

        if (k < DIST_W - 1) begin : g_carry
            logic [REM_W-1:0] n_rem;
            assign n_rem = w_ge ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];

            always_ff @(posedge i_clk) begin
                if (i_ctl.ce) begin
                    r_rem[k] <= n_rem;
                    r_rad[k] <= {w_rad_in[SUM_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_vld[DIST_W-1];
    assign o_root  = r_root[DIST_W-1];

endmodule

// ===== design/pairwise_distance_3d.sv =====
// Euclidean distance between two 3D points in 24-bit fixed point.
// Pipeline: 3 arithmetic stages, then 25 root stages, from input transfer to result.
// Throughput: one pair per cycle unless stalled; the root unit resolves one result bit per stage.
// Back-pressure on the result stalls the whole pipeline, nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears the valid bits only; no state is kept.
module pairwise_distance_3d (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream. tdata from bit 0: first_x, first_y, first_z,
    // second_x, second_y, second_z, 24 bits each, signed.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pwd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // Result stream. tdata from bit 0: distance (25 bits, unsigned),
    // then seven zero bits.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pwd_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import pwd_pkg::*;

    // The pipeline moves as one whenever the result register is free or is
    // being emptied in this cycle. Bubbles travel with it.
    logic w_ce;
    assign w_ce       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_ce;

    // Unpack the six coordinates.
    logic signed [COORD_W-1:0] w_coord [N_COORD];
    for (genvar c = 0; c < N_COORD; c++) begin : g_unpack
        assign w_coord[c] = i_s_tdata[c*COORD_W +: COORD_W];
    end

    // Stage 1: per-axis difference and its magnitude. The difference needs
    // one extra bit, but its magnitude never exceeds 2^24 - 1.
    logic             r_v1;
    logic [MAG_W-1:0] r_mag [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [COORD_W:0] w_diff;
        logic        [COORD_W:0] w_abs;
        assign w_diff = {w_coord[a][COORD_W-1], w_coord[a]}
                      - {w_coord[a+3][COORD_W-1], w_coord[a+3]};
        assign w_abs  = w_diff[COORD_W] ? (-w_diff) : w_diff;

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_mag[a] <= w_abs[MAG_W-1:0];
            end
        end
    end

    // Stage 2: square each magnitude, one 24 x 24 multiplier per axis.
    logic            r_v2;
    logic [SQ_W-1:0] r_sq [3];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= r_mag[a] * r_mag[a];
            end
        end
    end

    // Stage 3: exact sum of the three squares; it stays below 3 * 2^48.
    logic             r_v3;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    assign n_sum = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_ce) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Floor square root of the sum. Its last stage is the result register,
    // which holds the distance for as long as the consumer stalls.
    t_sqrt_ctl         w_ctl;
    logic [DIST_W-1:0] w_root;

    assign w_ctl.ce    = w_ce;
    assign w_ctl.valid = r_v3;

    pwd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_radicand (r_sum),
        .o_valid    (o_m_tvalid),
        .o_root     (w_root)
    );

    assign o_m_tdata = {{(OUT_DATA_W - DIST_W){1'b0}}, w_root};

endmodule

// ===== design/pwd_checker.sv =====
// Port-level checker for the pairwise distance block, bound to the top level.
// Depends on pwd_pkg and the assertion macros in pairwise_distance_3d_defines.svh.
`include "pairwise_distance_3d_defines.svh"

module pwd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [pwd_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import pwd_pkg::*;

    // A stalled result stays offered and unchanged.
    `PWD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // The block never refuses input while its result register is empty.
    `PWD_ASSERT_NOW(a_ready, i_clk, i_rst_n, !o_m_tvalid || i_m_tready, o_s_tready)

    // Padding above the distance is always zero.
    `PWD_ASSERT_NOW(a_pad, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[OUT_DATA_W-1:DIST_W] == '0)

    // The distance cannot exceed the root of three full-scale squares.
    `PWD_ASSERT_NOW(a_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[DIST_W-1:0] <= 25'd29058990)

endmodule

bind pairwise_distance_3d pwd_checker u_pwd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== dv/tb_pairwise_distance_3d.sv =====
// Self-checking testbench for pairwise_distance_3d: point pairs in, distances out.
// Relies only on pwd_pkg and the block itself; expected distances come from
// an independent exact-integer predictor held in a small scoreboard class.
`timescale 1ns / 1ps

module tb_pairwise_distance_3d;
    import pwd_pkg::*;

    // One input transfer: two points, each coordinate signed with 12 fraction bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_x;
    } coord_pair_t;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam int RANDOM_PAIRS = 800;
    localparam int SETTLE_CYCLES = 60;   // comfortably beyond the pipeline latency

    // Holds the distances still owed by the block, oldest first, and compares
    // every result transfer against the head of that list.
    class distance_scoreboard;
        bit [DIST_W-1:0] owed_distances[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Exact squared length in 64-bit arithmetic, then the floor root found
        // one bit at a time from the top: keep a bit if its square still fits.
        function bit [DIST_W-1:0] distance_of(coord_pair_t p);
            longint dx, dy, dz;
            longint unsigned sum_sq, root, trial;
            dx = longint'(p.first_x) - longint'(p.second_x);
            dy = longint'(p.first_y) - longint'(p.second_y);
            dz = longint'(p.first_z) - longint'(p.second_z);
            sum_sq = dx * dx + dy * dy + dz * dz;
            root = 0;
            for (int b = DIST_W; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sum_sq)
                    root = trial;
            end
            return root[DIST_W-1:0];
        endfunction

        function void note_pair(coord_pair_t p);
            owed_distances.push_back(distance_of(p));
        endfunction

        function void check_distance(logic [OUT_DATA_W-1:0] word);
            bit [DIST_W-1:0] want;
            if (owed_distances.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual distance %0d",
                         $time, word[DIST_W-1:0]);
                return;
            end
            want = owed_distances.pop_front();
            if (word[DIST_W-1:0] !== want) begin
                errors++;
                $display("%0t: distance mismatch, expected %0d, actual %0d",
                         $time, want, word[DIST_W-1:0]);
            end
            if (word[OUT_DATA_W-1:DIST_W] !== '0) begin
                errors++;
                $display("%0t: padding bits mismatch, expected 0, actual 'h%0h",
                         $time, word[OUT_DATA_W-1:DIST_W]);
            end
        endfunction

        function int pending();
            return owed_distances.size();
        endfunction
    endclass

    // Every block input starts at a known value.
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;  // first_x, first_y, first_z, second_x/y/z
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;        // distance (25 bits), then zero padding

    distance_scoreboard sb;

    pairwise_distance_3d dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Receiver side. Results are checked on the edge at which a transfer
    // completes; the ready line then follows a pattern that changes mode now
    // and again, so that fully open stretches alternate with light, sparse
    // and long stalls. Values read here are those held before the edge.
    typedef enum int { READY_OPEN, READY_COIN, READY_SPARSE, READY_LONG_HOLD } ready_mode_t;
    ready_mode_t ready_mode = READY_OPEN;
    int          mode_cycles_left = 0;
    int          hold_cycles_left = 0;
    logic        hold_level = 1'b1;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_distance(o_m_tdata);

        if (mode_cycles_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_cycles_left = $urandom_range(16, 200);
        end else begin
            mode_cycles_left--;
        end

        case (ready_mode)
            READY_OPEN: begin
                i_m_tready <= 1'b1;
            end
            READY_COIN: begin
                i_m_tready <= 1'($urandom_range(0, 1));
            end
            READY_SPARSE: begin
                i_m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (hold_cycles_left == 0) begin
                    hold_level = ~hold_level;
                    hold_cycles_left = $urandom_range(1, 20);
                end else begin
                    hold_cycles_left--;
                end
                i_m_tready <= hold_level;
            end
        endcase
    end

    // Presents one pair and holds it until the block takes it.
    task automatic send_pair(input coord_pair_t p);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {p.second_z, p.second_y, p.second_x, p.first_z, p.first_y, p.first_x};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_pair(p);
    endtask

    // Sender gap; the data lines carry rubbish while valid is low.
    task automatic idle_gap(input int cycles);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
        repeat (cycles)
            @(posedge i_clk);
    endtask

    // Holds the sender back until every owed distance has come out.
    // At least one edge always passes, so valid is never lowered and raised
    // again within one time step.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Coordinates come in as integers; only their low 24 bits are kept.
    function automatic coord_pair_t make_pair(
        input int fx, fy, fz, sx, sy, sz);
        coord_pair_t p;
        p.first_x = COORD_W'(fx); p.first_y = COORD_W'(fy); p.first_z = COORD_W'(fz);
        p.second_x = COORD_W'(sx); p.second_y = COORD_W'(sy); p.second_z = COORD_W'(sz);
        return p;
    endfunction

    // A coordinate biased towards the corners of the range.
    function automatic logic signed [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return -24'sd1;
            4: return 24'sd1;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // Random pairs: fully random points, close neighbours (small differences,
    // so the low root bits get exercised), corner values, and pairs that
    // differ along one axis only.
    function automatic coord_pair_t random_pair();
        coord_pair_t p;
        int          axis;
        p = coord_pair_t'({$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())});
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: begin
            end
            8, 9, 10, 11, 12, 13: begin
                p.second_x = p.first_x + COORD_W'($urandom_range(0, 8191) - 4096);
                p.second_y = p.first_y + COORD_W'($urandom_range(0, 8191) - 4096);
                p.second_z = p.first_z + COORD_W'($urandom_range(0, 8191) - 4096);
            end
            14, 15, 16: begin
                p = make_pair(corner_coord(), corner_coord(), corner_coord(),
                              corner_coord(), corner_coord(), corner_coord());
            end
            default: begin
                axis = $urandom_range(0, 2);
                if (axis != 0) p.second_x = p.first_x;
                if (axis != 1) p.second_y = p.first_y;
                if (axis != 2) p.second_z = p.first_z;
            end
        endcase
        return p;
    endfunction

    coord_pair_t directed_pairs[$];

    initial begin
        int sent;
        int burst;
        sb = new();

        // Directed cases: zero distance, opposite extremes on each axis and on
        // all of them together (the largest distance the block can produce),
        // truncation of the root just below and at perfect squares, sign
        // crossings and alternating bit patterns.
        directed_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        directed_pairs.push_back(make_pair(COORD_MAX, COORD_MAX, COORD_MAX,
                                           COORD_MAX, COORD_MAX, COORD_MAX));
        directed_pairs.push_back(make_pair(COORD_MIN, COORD_MIN, COORD_MIN,
                                           COORD_MIN, COORD_MIN, COORD_MIN));
        directed_pairs.push_back(make_pair(COORD_MAX, 0, 0, COORD_MIN, 0, 0));
        directed_pairs.push_back(make_pair(COORD_MIN, 0, 0, COORD_MAX, 0, 0));
        directed_pairs.push_back(make_pair(0, COORD_MAX, 0, 0, COORD_MIN, 0));
        directed_pairs.push_back(make_pair(0, 0, COORD_MIN, 0, 0, COORD_MAX));
        directed_pairs.push_back(make_pair(COORD_MIN, COORD_MIN, COORD_MIN,
                                           COORD_MAX, COORD_MAX, COORD_MAX));
        directed_pairs.push_back(make_pair(COORD_MAX, COORD_MAX, COORD_MAX,
                                           COORD_MIN, COORD_MIN, COORD_MIN));
        directed_pairs.push_back(make_pair(1, 0, 0, 0, 0, 0));
        directed_pairs.push_back(make_pair(1, 1, 1, 0, 0, 0));
        directed_pairs.push_back(make_pair(3, 4, 0, 0, 0, 0));
        directed_pairs.push_back(make_pair(2, 2, 1, 0, 0, 0));
        directed_pairs.push_back(make_pair(2, 2, 0, 0, 0, 0));
        directed_pairs.push_back(make_pair(-24'sd1, 0, 0, 0, 0, 0));
        directed_pairs.push_back(make_pair(24'sd4096, 0, 0, 0, 0, 0));
        directed_pairs.push_back(make_pair(24'sh555555, 24'sh555555, 24'sh555555,
                                           24'shAAAAAA, 24'shAAAAAA, 24'shAAAAAA));
        directed_pairs.push_back(make_pair(COORD_MAX, 24'sd1, 0, COORD_MIN, 0, 0));
        directed_pairs.push_back(make_pair(-24'sd3, 24'sd5, -24'sd7,
                                           24'sd3, -24'sd5, 24'sd7));

        repeat (12)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_pairs[i])
            send_pair(directed_pairs[i]);
        drain_results();

        // Random part in bursts of random length. Gaps are mostly short, now
        // and then long, and sometimes absent so that bursts run together.
        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_PAIRS; k++) begin
                send_pair(random_pair());
                sent++;
                if (sent == RANDOM_PAIRS / 2)
                    drain_results();
            end
            case ($urandom_range(0, 7))
                0, 1: begin
                end
                7: idle_gap($urandom_range(20, 40));
                default: idle_gap($urandom_range(1, 8));
            endcase
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Safety net: the slowest correct run is well under a tenth of this.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
